// ===== sv/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit page allocator package
// Request codes and result status codes used by the allocator module.
// ----------------------------------------------------------------------------
package ffpa_pkg;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ZERO    = 3'd1;
   localparam logic [2:0] ST_NOSPACE = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_NOTHEAD = 3'd4;

endpackage

// ===== sv/ffpa_table_ram.sv =====
// ----------------------------------------------------------------------------
// Page descriptor table RAM
// Single-port memory holding the in-use bit and run length of every page,
// with registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module ffpa_table_ram #(
   parameter int DEPTH = 1024,
   parameter int DW    = 12
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DW-1:0]            wdata,
   output logic [DW-1:0]            rdata
);

   logic [DW-1:0] table_ff [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            table_ff[addr] <= wdata;
         end else begin
            rdata_ff <= table_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/first_fit_page_allocator.sv =====
// ----------------------------------------------------------------------------
// First-fit page allocator
// Allocates, frees and sizes blocks of pages over a descriptor table, with
// coalescing of free runs on free and a high-water mark of allocated pages.
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  req_type, req_page_count,
//                                              req_page_index
//   rsp_      out         rsp_valid/rsp_stall  rsp_status, rsp_block_start,
//                                              rsp_block_pages, rsp_high_water
//   csr_      in          csr_we               csr_page_limit
//
// One request at a time through a single-port table RAM, one access a cycle.
// Allocate scans from page 0 for the first free run that fits; free merges
// with free runs after and before the block; query reads the head only.
// req_stall is high from acceptance and falls in the cycle in which rsp_valid
// rises. Reset and every page-limit write start a format pass, one page a cycle.
// A stalled result holds in the output register until taken.
// ----------------------------------------------------------------------------
module first_fit_page_allocator #(
   parameter int MAX_PAGES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [10:0] req_page_count,
   input  logic [9:0]  req_page_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_block_start,
   output logic [10:0] rsp_block_pages,
   output logic [10:0] rsp_high_water,
   input  logic        csr_we,
   input  logic [10:0] csr_page_limit
);

   import ffpa_pkg::*;

   localparam int IW = $clog2(MAX_PAGES);
   localparam int CW = $clog2(MAX_PAGES + 1);
   localparam int AW = ((CW > 11) ? CW : 11) + 2;
   localparam int RESET_TOTAL = (MAX_PAGES < 1024) ? MAX_PAGES : 1024;

   typedef enum logic [3:0] {
      S_FMT, S_IDLE, S_SCAN, S_MARK, S_HEAD, S_NEXT, S_BACK, S_WRITE, S_RESP
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] total_ff, total_in;
   logic [10:0]   high_ff, high_in;
   logic [1:0]    op_ff, op_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] to_ff, to_in;
   logic          pend_ff, pend_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic [9:0]    res_start_ff, res_start_in;
   logic [10:0]   res_pages_ff, res_pages_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [9:0]    rsp_start_ff, rsp_start_in;
   logic [10:0]   rsp_pages_ff, rsp_pages_in;
   logic [10:0]   rsp_high_ff, rsp_high_in;

   logic          mem_en, mem_we;
   logic [IW-1:0] mem_addr;
   logic [CW:0]   mem_wdata, rd_data;

   logic          rd_used;
   logic [AW-1:0] rd_runx, totalx, highx, csr_x, csr_clamp, head_end, cnt_new;

   ffpa_table_ram #(
      .DEPTH (MAX_PAGES),
      .DW    (CW + 1)
   ) u_table (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (rd_data)
   );

   assign rd_used = rd_data[CW];
   assign rd_runx = {{(AW-CW){1'b0}}, rd_data[CW-1:0]};
   assign totalx  = {{(AW-CW){1'b0}}, total_ff};
   assign highx   = {{(AW-11){1'b0}}, high_ff};
   assign csr_x   = {{(AW-11){1'b0}}, csr_page_limit};

   always_comb begin
      csr_clamp = csr_x;
      if (csr_x == '0) begin
         csr_clamp = AW'(1);
      end
      if (csr_x > AW'(MAX_PAGES)) begin
         csr_clamp = AW'(MAX_PAGES);
      end
   end

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      high_in       = high_ff;
      op_in         = op_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      ptr_in        = ptr_ff;
      to_in         = to_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_pages_in  = res_pages_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_high_in   = rsp_high_ff;
      mem_en        = 1'b0;
      mem_we        = 1'b0;
      mem_addr      = ptr_ff[IW-1:0];
      mem_wdata     = '0;
      head_end      = (ptr_ff - AW'(1)) + cnt_ff;
      cnt_new       = cnt_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_FMT: begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = {1'b0, CW'(totalx - ptr_ff)};
            ptr_in    = ptr_ff + AW'(1);
            if (ptr_ff + AW'(1) >= totalx) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_type;
               cnt_in        = {{(AW-11){1'b0}}, req_page_count};
               idx_in        = {{(AW-10){1'b0}}, req_page_index};
               res_status_in = ST_OK;
               res_start_in  = '0;
               res_pages_in  = '0;
               unique case (req_type) inside
                  REQ_ALLOC: begin
                     if (req_page_count == '0) begin
                        res_status_in = ST_ZERO;
                        state_in      = S_RESP;
                     end else begin
                        ptr_in   = '0;
                        pend_in  = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  REQ_FREE, REQ_QUERY: begin
                     if ({{(AW-10){1'b0}}, req_page_index} >= totalx) begin
                        res_status_in = ST_RANGE;
                        state_in      = S_RESP;
                     end else begin
                        mem_en   = 1'b1;
                        mem_addr = IW'({{(AW-10){1'b0}}, req_page_index});
                        state_in = S_HEAD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (pend_ff && !rd_used && (cnt_ff <= rd_runx)) begin
               mem_en       = 1'b1;
               mem_we       = 1'b1;
               mem_addr     = IW'(ptr_ff - AW'(1));
               mem_wdata    = {1'b1, cnt_ff[CW-1:0]};
               idx_in       = ptr_ff - AW'(1);
               res_start_in = 10'(ptr_ff - AW'(1));
               res_pages_in = cnt_ff[10:0];
               if (highx < head_end) begin
                  high_in = head_end[10:0];
               end
               state_in = S_MARK;
            end else if (ptr_ff < totalx) begin
               mem_en  = 1'b1;
               ptr_in  = ptr_ff + AW'(1);
               pend_in = 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               res_status_in = ST_NOSPACE;
               state_in      = S_RESP;
            end
         end
         S_MARK: begin
            if ((ptr_ff < idx_ff + cnt_ff) && (ptr_ff < totalx)) begin
               mem_en    = 1'b1;
               mem_we    = 1'b1;
               mem_wdata = {1'b1, {CW{1'b0}}};
               ptr_in    = ptr_ff + AW'(1);
            end else begin
               state_in = S_RESP;
            end
         end
         S_HEAD: begin
            if (!rd_used || (rd_runx == '0)) begin
               res_status_in = ST_NOTHEAD;
               state_in      = S_RESP;
            end else begin
               res_pages_in = rd_runx[10:0];
               cnt_in       = rd_runx;
               to_in        = idx_ff + rd_runx;
               if (op_ff == REQ_QUERY) begin
                  state_in = S_RESP;
               end else if (idx_ff + rd_runx < totalx) begin
                  mem_en   = 1'b1;
                  mem_addr = IW'(idx_ff + rd_runx);
                  state_in = S_NEXT;
               end else begin
                  ptr_in = idx_ff;
                  if (idx_ff != '0) begin
                     mem_en   = 1'b1;
                     mem_addr = IW'(idx_ff - AW'(1));
                     state_in = S_BACK;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
            end
         end
         S_NEXT: begin
            if (!rd_used && (to_ff + rd_runx <= totalx)) begin
               cnt_new = cnt_ff + rd_runx;
            end
            cnt_in = cnt_new;
            ptr_in = idx_ff;
            if (idx_ff != '0) begin
               mem_en   = 1'b1;
               mem_addr = IW'(idx_ff - AW'(1));
               state_in = S_BACK;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_BACK: begin
            if (!rd_used && (rd_runx != '0)) begin
               ptr_in = ptr_ff - AW'(1);
               cnt_in = cnt_ff + AW'(1);
               if (ptr_ff - AW'(1) != '0) begin
                  mem_en   = 1'b1;
                  mem_addr = IW'(ptr_ff - AW'(2));
               end else begin
                  state_in = S_WRITE;
               end
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if ((ptr_ff < to_ff) && (ptr_ff < totalx)) begin
               mem_en    = 1'b1;
               mem_we    = 1'b1;
               mem_wdata = {1'b0, cnt_ff[CW-1:0]};
               ptr_in    = ptr_ff + AW'(1);
               cnt_in    = cnt_ff - AW'(1);
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_pages_in  = res_pages_ff;
               rsp_high_in   = high_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         total_in = csr_clamp[CW-1:0];
         high_in  = '0;
         ptr_in   = '0;
         state_in = S_FMT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FMT;
         total_ff     <= CW'(RESET_TOTAL);
         high_ff      <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         high_ff      <= high_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      cnt_ff        <= cnt_in;
      idx_ff        <= idx_in;
      to_ff         <= to_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_pages_ff  <= res_pages_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_high_ff   <= rsp_high_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_start = rsp_start_ff;
   assign rsp_block_pages = rsp_pages_ff;
   assign rsp_high_water  = rsp_high_ff;

endmodule
